@@ hdl/awba_pkg.sv @@
// shared types and constants for the area weighted box average unit
`default_nettype none
package awba_pkg;

  localparam int PIX_W      = 16;
  localparam int WORD_W     = 4 * PIX_W;
  localparam int COORD_W    = 15;
  localparam int AREA_W     = 2 * COORD_W;
  localparam int QUO_W      = 17;
  localparam int DIM_W      = 7;
  localparam int PXY_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int DEF_MAX_WIDTH       = 64;
  localparam int DEF_MAX_HEIGHT      = 64;
  localparam int DEF_COORD_FRAC_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_FIN
  } awba_state_t;

endpackage
`default_nettype wire

@@ hdl/awba_in_if.sv @@
// input channel: pixel writes and rectangle queries
`default_nettype none
interface awba_in_if import awba_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [PXY_W-1:0]          pixel_x;
  logic [PXY_W-1:0]          pixel_y;
  logic signed [PIX_W-1:0]   red_in;
  logic signed [PIX_W-1:0]   green_in;
  logic signed [PIX_W-1:0]   blue_in;
  logic signed [PIX_W-1:0]   alpha_in;
  logic [COORD_W-1:0]        x_left;
  logic [COORD_W-1:0]        x_right;
  logic [COORD_W-1:0]        y_top;
  logic [COORD_W-1:0]        y_bottom;

  modport source (output valid, func, pixel_x, pixel_y, red_in, green_in, blue_in,
                  alpha_in, x_left, x_right, y_top, y_bottom, input ready);
  modport sink (input valid, func, pixel_x, pixel_y, red_in, green_in, blue_in,
                alpha_in, x_left, x_right, y_top, y_bottom, output ready);
endinterface
`default_nettype wire

@@ hdl/awba_out_if.sv @@
// result channel: one average word per query
`default_nettype none
interface awba_out_if import awba_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [PIX_W-1:0]   red_avg;
  logic signed [PIX_W-1:0]   green_avg;
  logic signed [PIX_W-1:0]   blue_avg;
  logic signed [PIX_W-1:0]   alpha_avg;
  logic                      bad_area;

  modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, bad_area,
                  input ready);
  modport sink (input valid, red_avg, green_avg, blue_avg, alpha_avg, bad_area,
                output ready);
endinterface
`default_nettype wire

@@ hdl/awba_cfg_if.sv @@
// configuration write channel
`default_nettype none
interface awba_cfg_if import awba_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [DIM_W-1:0]      data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/awba_div.sv @@
// rounding divider with q8.8 saturation, one quotient bit per cycle
`default_nettype none
module awba_div import awba_pkg::*; #(
  parameter int SUM_W = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  sum,
  input  wire logic [AREA_W-1:0]        area,
  output logic                          done,
  output logic [PIX_W-1:0]              avg
);

  localparam int D_W  = AREA_W + 1;
  localparam int N_W  = (SUM_W + 2 > D_W + QUO_W) ? SUM_W + 2 : D_W + QUO_W;
  localparam int LAST = QUO_W + 2;

  logic              busy_r;
  logic [4:0]        step_r;
  logic              neg_r;
  logic [SUM_W-1:0]  mag_r;
  logic [AREA_W-1:0] a_r;
  logic [N_W-1:0]    n_r;
  logic [D_W-1:0]    rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  q_r;
  logic              sat_r;
  logic              done_r;
  logic [PIX_W-1:0]  avg_r;

  logic [D_W-1:0]    d;
  logic [D_W:0]      t;
  logic              ge;
  logic [D_W-1:0]    rem_nxt;
  logic [PIX_W-1:0]  avg_nxt;

  assign d       = {a_r, 1'b0};
  assign t       = {rem_r, low_r[QUO_W-1]};
  assign ge      = t >= {1'b0, d};
  assign rem_nxt = ge ? D_W'(t - {1'b0, d}) : D_W'(t);

  always_comb begin
    if (neg_r) begin
      avg_nxt = (sat_r || q_r > QUO_W'(32768)) ? 16'h8000 : PIX_W'(-q_r);
    end else begin
      avg_nxt = (sat_r || q_r > QUO_W'(32767)) ? 16'h7fff : q_r[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(LAST)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= sum[SUM_W-1];
      mag_r <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      a_r   <= area;
    end else if (busy_r) begin
      if (step_r == 5'd0) begin
        n_r <= N_W'({mag_r, 1'b0}) + N_W'(a_r);
      end else if (step_r == 5'd1) begin
        sat_r <= n_r >= (N_W'(d) << QUO_W);
        rem_r <= D_W'(n_r >> QUO_W);
        low_r <= n_r[QUO_W-1:0];
        q_r   <= '0;
      end else if (step_r < 5'(LAST)) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], ge};
      end else begin
        avg_r <= avg_nxt;
      end
    end
  end

  assign done = done_r;
  assign avg  = avg_r;

endmodule
`default_nettype wire

@@ hdl/area_weighted_box_average_unit.sv @@
// top level of the area weighted box average unit
// A write word stores one signed q8.8 rgba pixel in a single-port-read pixel memory.
// A query word scans every pixel its rectangle touches, one memory read per cycle,
// weights each by its covered area and accumulates the four channels; four rounding
// dividers then produce the averages. A rejected rectangle (empty or outside the
// image) returns bad_area with zero averages. The pixel memory has no reset; only
// pixels written before a query may be covered.
`default_nettype none
module area_weighted_box_average_unit import awba_pkg::*; #(
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  awba_in_if.sink    in_ch,
  awba_out_if.source out_ch,
  awba_cfg_if.sink   cfg_ch
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WTW   = COORD_FRAC_BITS + 1;
  localparam int PW    = 2 * WTW;
  localparam int PRW   = PW + 1 + PIX_W;
  localparam int SUM_W = PRW + AW + 1;
  localparam logic [16:0] ONE = 17'(1 << COORD_FRAC_BITS);

  function automatic logic [WTW-1:0] axis_wt(input logic [15:0] i, input logic [15:0] lo,
                                             input logic [15:0] hi,
                                             input logic [15:0] first,
                                             input logic [15:0] last);
    logic [23:0] v;
    if (first == last) begin
      v = 24'(hi) - 24'(lo);
    end else if (i == first) begin
      v = ((24'(first) + 24'd1) << COORD_FRAC_BITS) - 24'(lo);
    end else if (i == last) begin
      v = 24'(hi) - (24'(last) << COORD_FRAC_BITS);
    end else begin
      v = 24'(ONE);
    end
    return WTW'(v);
  endfunction

  // configuration
  logic [DIM_W-1:0] image_width_r, image_height_r;
  logic [31:0]      w_eff, h_eff;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_W'(64);
      image_height_r <= DIM_W'(64);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_ch.data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = 32'(image_width_r);
    h_eff = 32'(image_height_r);
    if (w_eff == 32'd0) w_eff = 32'd1;
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    if (h_eff == 32'd0) h_eff = 32'd1;
    if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
  end

  // control
  awba_state_t state_r, state_nxt;
  logic        accept, is_query, bad;
  logic        scan_issue, last_pix, div_start, fin_load;
  logic [1:0]  drain_r;
  logic        div_done;

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_query = in_ch.func == FUNC_QUERY;
  assign bad = (in_ch.x_right <= in_ch.x_left) || (in_ch.y_bottom <= in_ch.y_top) ||
               (32'(in_ch.x_right) > (w_eff << COORD_FRAC_BITS)) ||
               (32'(in_ch.y_bottom) > (h_eff << COORD_FRAC_BITS));

  logic [XW-1:0] x_r, x0_r, x1_r;
  logic [YW-1:0] y_r, y0_r, y1_r;
  logic [COORD_W-1:0] xl_r, xr_r, yt_r, yb_r;
  logic          bad_r;
  logic          out_valid_r;

  assign last_pix = (x_r == x1_r) && (y_r == y1_r);

  always_comb begin
    in_ch.ready = 1'b0;
    scan_issue  = 1'b0;
    div_start   = 1'b0;
    fin_load    = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SCAN:  scan_issue  = 1'b1;
      ST_DRAIN: div_start   = drain_r == 2'd2;
      ST_DIV:   ;
      ST_FIN:   fin_load    = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && is_query) state_nxt = bad ? ST_FIN : ST_SCAN;
      ST_SCAN:  if (last_pix) state_nxt = ST_DRAIN;
      ST_DRAIN: if (div_start) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= (state_r == ST_DRAIN) ? drain_r + 2'd1 : 2'd0;
    end
  end

  // query setup and scan counters
  logic [16:0] xr_ceil, yb_ceil;
  assign xr_ceil = (17'(in_ch.x_right) + ONE - 17'd1) >> COORD_FRAC_BITS;
  assign yb_ceil = (17'(in_ch.y_bottom) + ONE - 17'd1) >> COORD_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      xl_r  <= in_ch.x_left;
      xr_r  <= in_ch.x_right;
      yt_r  <= in_ch.y_top;
      yb_r  <= in_ch.y_bottom;
      bad_r <= bad;
      x0_r  <= XW'(in_ch.x_left >> COORD_FRAC_BITS);
      y0_r  <= YW'(in_ch.y_top >> COORD_FRAC_BITS);
      x1_r  <= XW'(xr_ceil - 17'd1);
      y1_r  <= YW'(yb_ceil - 17'd1);
      x_r   <= XW'(in_ch.x_left >> COORD_FRAC_BITS);
      y_r   <= YW'(in_ch.y_top >> COORD_FRAC_BITS);
    end else if (scan_issue) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + YW'(1);
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
  end

  logic [AREA_W-1:0] area_r;
  always_ff @(posedge clk) begin
    area_r <= AREA_W'(xr_r - xl_r) * AREA_W'(yb_r - yt_r);
  end

  // pixel memory
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;

  assign mem_we = accept && !is_query && (32'(in_ch.pixel_x) < MAX_WIDTH) &&
                  (32'(in_ch.pixel_y) < MAX_HEIGHT);
  assign waddr  = AW'(32'(in_ch.pixel_y) * MAX_WIDTH + 32'(in_ch.pixel_x));
  assign raddr  = AW'(32'(y_r) * MAX_WIDTH + 32'(x_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};
    end
    rdata_r <= mem[raddr];
  end

  // weight, multiply, accumulate
  logic [WTW-1:0] wx, wy;
  logic [PW-1:0]  wt_r;
  logic           va_r, vb_r;
  logic signed [PRW-1:0]   prod_r [4];
  logic signed [SUM_W-1:0] sum_r  [4];

  assign wx = axis_wt(16'(x_r), 16'(xl_r), 16'(xr_r), 16'(x0_r), 16'(x1_r));
  assign wy = axis_wt(16'(y_r), 16'(yt_r), 16'(yb_r), 16'(y0_r), 16'(y1_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= scan_issue;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= PW'(wx) * PW'(wy);
  end

  for (genvar c = 0; c < 4; c++) begin : g_ch
    always_ff @(posedge clk) begin
      prod_r[c] <= PRW'($signed({1'b0, wt_r})) * PRW'($signed(rdata_r[PIX_W*c +: PIX_W]));
      if (accept) begin
        sum_r[c] <= '0;
      end else if (vb_r) begin
        sum_r[c] <= sum_r[c] + SUM_W'(prod_r[c]);
      end
    end
  end

  // dividers
  logic [PIX_W-1:0] avg [4];
  logic [3:0]       done_v;

  for (genvar c = 0; c < 4; c++) begin : g_div
    awba_div #(.SUM_W(SUM_W)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .sum   (sum_r[c]),
      .area  (area_r),
      .done  (done_v[c]),
      .avg   (avg[c])
    );
  end

  assign div_done = &done_v;

  // result register
  logic [PIX_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic             bad_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      red_r     <= bad_r ? '0 : avg[0];
      green_r   <= bad_r ? '0 : avg[1];
      blue_r    <= bad_r ? '0 : avg[2];
      alpha_r   <= bad_r ? '0 : avg[3];
      bad_out_r <= bad_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_avg   = red_r;
  assign out_ch.green_avg = green_r;
  assign out_ch.blue_avg  = blue_r;
  assign out_ch.alpha_avg = alpha_r;
  assign out_ch.bad_area  = bad_out_r;

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside finish");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (state_r == ST_DRAIN || state_r == ST_SCAN))
    else $error("accumulate outside scan");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_out_r) |-> (red_r == '0 && alpha_r == '0))
    else $error("bad area with nonzero average");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE)
    else $error("pixel write while busy");

endmodule
`default_nettype wire

@@ test/awba_checker.sv @@
// checker: watches all channels, predicts box averages and compares results
`timescale 1ns / 1ps
module awba_checker import awba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  awba_in_if        in_ch,
  awba_out_if       out_ch,
  awba_cfg_if       cfg_ch,
  output int        errors,
  output int        pending
);

  typedef struct {
    logic signed [PIX_W-1:0] red;
    logic signed [PIX_W-1:0] green;
    logic signed [PIX_W-1:0] blue;
    logic signed [PIX_W-1:0] alpha;
    logic                    bad;
  } avg_word_t;

  localparam int ONE = 1 << DEF_COORD_FRAC_BITS;

  logic [WORD_W-1:0] pixel_mirror [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  avg_word_t         expected_avgs [$];

  assign pending = expected_avgs.size();

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint axis_weight(input int i, input int lo, input int hi,
                                         input int first, input int last);
    if (first == last) return hi - lo;
    if (i == first) return ((first + 1) * ONE) - lo;
    if (i == last) return hi - last * ONE;
    return ONE;
  endfunction

  function automatic logic [PIX_W-1:0] round_sat(input longint acc, input longint area);
    longint mag;
    longint q;
    mag = (acc < 0) ? -acc : acc;
    q = (2 * mag + area) / (2 * area);
    if (acc < 0) return (q > 32768) ? 16'h8000 : PIX_W'(-q);
    return (q > 32767) ? 16'h7fff : PIX_W'(q);
  endfunction

  function automatic avg_word_t box_average(input logic [COORD_W-1:0] xl,
                                            input logic [COORD_W-1:0] xr,
                                            input logic [COORD_W-1:0] yt,
                                            input logic [COORD_W-1:0] yb);
    avg_word_t res;
    int w, h, x0, x1, y0, y1;
    longint area, wt;
    longint acc [4];
    logic [WORD_W-1:0] p;
    logic [PIX_W-1:0] ch [4];
    res = '{red: 0, green: 0, blue: 0, alpha: 0, bad: 1'b1};
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (xr <= xl || yb <= yt || int'(xr) > w * ONE || int'(yb) > h * ONE) return res;
    x0 = xl / ONE;
    x1 = (int'(xr) + ONE - 1) / ONE - 1;
    y0 = yt / ONE;
    y1 = (int'(yb) + ONE - 1) / ONE - 1;
    area = longint'(xr - xl) * longint'(yb - yt);
    for (int c = 0; c < 4; c++) acc[c] = 0;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        wt = axis_weight(y, yt, yb, y0, y1) * axis_weight(x, xl, xr, x0, x1);
        p = pixel_mirror[y * DEF_MAX_WIDTH + x];
        for (int c = 0; c < 4; c++) acc[c] += wt * longint'($signed(p[PIX_W*c +: PIX_W]));
      end
    end
    for (int c = 0; c < 4; c++) ch[c] = round_sat(acc[c], area);
    res = '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3], bad: 1'b0};
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    avg_word_t exp_w;
    if (!rst_n) begin
      width_reg  <= 7'd64;
      height_reg <= 7'd64;
      expected_avgs.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_IMAGE_WIDTH:  width_reg  <= cfg_ch.data;
          CFG_IMAGE_HEIGHT: height_reg <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_WRITE)
          pixel_mirror[{in_ch.pixel_y, in_ch.pixel_x}] =
            {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};
        else
          expected_avgs.push_back(box_average(in_ch.x_left, in_ch.x_right,
                                              in_ch.y_top, in_ch.y_bottom));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          exp_w = expected_avgs.pop_front();
          if (out_ch.red_avg !== exp_w.red)
            report_mismatch($sformatf("red %h exp %h", out_ch.red_avg, exp_w.red));
          if (out_ch.green_avg !== exp_w.green)
            report_mismatch($sformatf("green %h exp %h", out_ch.green_avg, exp_w.green));
          if (out_ch.blue_avg !== exp_w.blue)
            report_mismatch($sformatf("blue %h exp %h", out_ch.blue_avg, exp_w.blue));
          if (out_ch.alpha_avg !== exp_w.alpha)
            report_mismatch($sformatf("alpha %h exp %h", out_ch.alpha_avg, exp_w.alpha));
          if (out_ch.bad_area !== exp_w.bad)
            report_mismatch($sformatf("bad_area %b exp %b", out_ch.bad_area, exp_w.bad));
        end
      end
    end
  end

endmodule

@@ test/area_weighted_box_average_unit_tb.sv @@
// testbench top: stimulus, flow control and verdict for the box average unit
`timescale 1ns / 1ps
module area_weighted_box_average_unit_tb;
  import awba_pkg::*;

  localparam int ONE = 1 << DEF_COORD_FRAC_BITS;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  int   err_count;
  int   exp_pending;
  int   cycles;
  int   in_idle;
  int   out_stall;
  bit   hold_go;
  int   items;
  int   eff_w, eff_h;
  bit   written [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];

  awba_in_if  in_ch ();
  awba_out_if out_ch ();
  awba_cfg_if cfg_ch ();

  area_weighted_box_average_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  awba_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(err_count), .pending(exp_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[area_weighted_box_average_unit] ERROR");
      $finish;
    end
  end

  // result side flow control, with one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 1'b0;
      out_ch.ready <= 1'b0;
      repeat (600) @(posedge clk);
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall);
    end
  end

  task automatic send_word(input logic f, input logic [5:0] px, input logic [5:0] py,
                           input logic [63:0] rgba, input logic [14:0] xl,
                           input logic [14:0] xr, input logic [14:0] yt,
                           input logic [14:0] yb);
    if ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.pixel_x  <= px;
    in_ch.pixel_y  <= py;
    in_ch.red_in   <= rgba[15:0];
    in_ch.green_in <= rgba[31:16];
    in_ch.blue_in  <= rgba[47:32];
    in_ch.alpha_in <= rgba[63:48];
    in_ch.x_left   <= xl;
    in_ch.x_right  <= xr;
    in_ch.y_top    <= yt;
    in_ch.y_bottom <= yb;
    do @(posedge clk); while (!in_ch.ready);
    items++;
  endtask

  function automatic logic [63:0] rand_rgba();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_pixel(input int x, input int y, input logic [63:0] rgba);
    send_word(FUNC_WRITE, 6'(x), 6'(y), rgba, 15'($urandom), 15'($urandom),
              15'($urandom), 15'($urandom));
    written[y][x] = 1'b1;
  endtask

  task automatic query_rect(input int xl, input int xr, input int yt, input int yb);
    if (xr > xl && yb > yt && xr <= eff_w * ONE && yb <= eff_h * ONE) begin
      for (int y = yt / ONE; y <= (yb + ONE - 1) / ONE - 1; y++)
        for (int x = xl / ONE; x <= (xr + ONE - 1) / ONE - 1; x++)
          if (!written[y][x]) write_pixel(x, y, rand_rgba());
    end
    send_word(FUNC_QUERY, 6'($urandom), 6'($urandom), rand_rgba(), 15'(xl), 15'(xr),
              15'(yt), 15'(yb));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    wait_drained();
    repeat (40) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) eff_w = (v == 0) ? 1 : (v > 64) ? 64 : v;
    else eff_h = (v == 0) ? 1 : (v > 64) ? 64 : v;
  endtask

  task automatic random_query();
    int x0, y0, sx, sy;
    int xl, yt;
    if ($urandom_range(99) < 15) begin
      query_rect($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                 $urandom_range(32767));
    end else begin
      x0 = $urandom_range(eff_w - 1);
      y0 = $urandom_range(eff_h - 1);
      sx = ($urandom_range(9) == 0) ? $urandom_range(1, eff_w - x0)
                                    : $urandom_range(1, (eff_w - x0 < 4) ? eff_w - x0 : 4);
      sy = ($urandom_range(9) == 0) ? $urandom_range(1, eff_h - y0)
                                    : $urandom_range(1, (eff_h - y0 < 4) ? eff_h - y0 : 4);
      xl = x0 * ONE + $urandom_range(ONE - 1);
      yt = y0 * ONE + $urandom_range(ONE - 1);
      query_rect(xl, xl + 1 + $urandom_range((x0 + sx) * ONE - xl - 1),
                 yt, yt + 1 + $urandom_range((y0 + sy) * ONE - yt - 1));
    end
  endtask

  initial begin
    int target;
    bit held;
    bit drained;
    cycles = 0;
    items = 0;
    hold_go = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    in_idle = 0;
    out_stall = 0;
    eff_w = 64;
    eff_h = 64;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_WRITE;
    in_ch.pixel_x <= '0;
    in_ch.pixel_y <= '0;
    in_ch.red_in <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in <= '0;
    in_ch.alpha_in <= '0;
    in_ch.x_left <= '0;
    in_ch.x_right <= '0;
    in_ch.y_top <= '0;
    in_ch.y_bottom <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= CFG_IMAGE_WIDTH;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme pixels, exact, fractional, single column, empty, outside
    write_pixel(0, 0, 64'h7fff_7fff_7fff_7fff);
    write_pixel(1, 0, 64'h8000_8000_8000_8000);
    write_pixel(0, 1, 64'h0000_0000_0000_0000);
    write_pixel(1, 1, 64'h8000_7fff_0001_ffff);
    write_pixel(63, 63, 64'h7fff_8000_7fff_8000);
    query_rect(0, ONE, 0, ONE);
    query_rect(0, 2 * ONE, 0, 2 * ONE);
    query_rect(ONE / 2, ONE + ONE / 2, ONE / 4, ONE + 3 * ONE / 4);
    query_rect(10, 200, 0, 2 * ONE);
    query_rect(0, 2 * ONE, 30, 31);
    query_rect(63 * ONE + 1, 64 * ONE, 63 * ONE, 64 * ONE);
    query_rect(ONE, ONE, 0, ONE);
    query_rect(2 * ONE, ONE, 0, ONE);
    query_rect(0, ONE, ONE, ONE);
    query_rect(0, 64 * ONE + 1, 0, ONE);
    query_rect(0, ONE, 0, 32767);
    query_rect(32767, 32767, 32767, 32767);
    write_reg(CFG_IMAGE_WIDTH, 7'd1);
    write_reg(CFG_IMAGE_HEIGHT, 7'd1);
    query_rect(0, ONE, 0, ONE);
    query_rect(0, ONE + 1, 0, ONE);
    query_rect(0, ONE, 0, ONE + 1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_IMAGE_WIDTH, 7'd64); write_reg(CFG_IMAGE_HEIGHT, 7'd64); end
        1: begin write_reg(CFG_IMAGE_WIDTH, 7'd0); write_reg(CFG_IMAGE_HEIGHT, 7'd127); end
        2: begin write_reg(CFG_IMAGE_WIDTH, 7'd127); write_reg(CFG_IMAGE_HEIGHT, 7'd0); end
        3: begin write_reg(CFG_IMAGE_WIDTH, 7'd8); write_reg(CFG_IMAGE_HEIGHT, 7'd5); end
        default: begin
          write_reg(CFG_IMAGE_WIDTH, 7'($urandom_range(1, 127)));
          write_reg(CFG_IMAGE_HEIGHT, 7'($urandom_range(1, 127)));
        end
      endcase
      in_idle   = (ph % 4 == 1) ? 78 : (ph % 4 == 3) ? 6 : 0;
      out_stall = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 6 : 0;
      target = items + 220;
      while (items < target) begin
        if (ph == 0 && !held) begin
          hold_go = 1'b1;
          held = 1'b1;
        end
        if (ph == 4 && !drained && items >= target - 100) begin
          wait_drained();
          drained = 1'b1;
        end
        if ($urandom_range(99) < 45) random_query();
        else write_pixel($urandom_range(63), $urandom_range(63), rand_rgba());
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("[area_weighted_box_average_unit] OK");
    else
      $display("[area_weighted_box_average_unit] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/awba_pkg.sv
hdl/awba_in_if.sv
hdl/awba_out_if.sv
hdl/awba_cfg_if.sv
hdl/awba_div.sv
hdl/area_weighted_box_average_unit.sv
test/awba_checker.sv
test/area_weighted_box_average_unit_tb.sv
